// ===== sv/glyph_pixel_rasterizer_3x5_unit_macros.svh =====
// Assertion macros used by the rasterizer back end.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef GLYPH_PIXEL_RASTERIZER_3X5_UNIT_MACROS_SVH
`define GLYPH_PIXEL_RASTERIZER_3X5_UNIT_MACROS_SVH

// Checked only outside reset.
`define GPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define GPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/gpr3x5_pkg.sv =====
// Shared types, font ROM and cell helpers for the 3x5 glyph rasterizer.
// No dependencies.
package gpr3x5_pkg;

    localparam int GLYPH_W   = 3;
    localparam int GLYPH_H   = 5;
    localparam int CELLS     = GLYPH_W * GLYPH_H;
    localparam int GLYPHS    = 38;

    localparam logic [5:0] IDX_COLON = 6'd10;
    localparam logic [5:0] IDX_BANG  = 6'd11;
    localparam logic [5:0] IDX_ALPHA = 6'd12;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    localparam logic [1:0] SCALE_ONE = 2'd1;
    localparam logic [1:0] SCALE_TWO = 2'd2;

    typedef logic [5:0]       t_glyph_idx;
    typedef logic [CELLS-1:0] t_cell_mask;
    typedef logic [3:0]       t_cell_idx;

    // Job handed from the front to the back: lit cells, row-major, bit 0 = top left.
    typedef struct packed {
        t_cell_mask  mask;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        s2;
    } t_job;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [7:0]         pixel_red;
        logic [7:0]         pixel_green;
        logic [7:0]         pixel_blue;
        logic               last_pixel;
    } t_pixel;

    // Row bits: bit 2 is the left column.
    localparam logic [2:0] GLYPH_ROM [GLYPHS][GLYPH_H] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd1, 3'd2, 3'd2, 3'd2},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
        '{3'd0, 3'd2, 3'd0, 3'd2, 3'd0}, // colon
        '{3'd2, 3'd2, 3'd2, 3'd0, 3'd2}, // exclamation mark
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd5}, '{3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
        '{3'd7, 3'd4, 3'd4, 3'd4, 3'd7}, '{3'd6, 3'd5, 3'd5, 3'd5, 3'd6},
        '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd4, 3'd7, 3'd4, 3'd4},
        '{3'd7, 3'd4, 3'd5, 3'd5, 3'd7}, '{3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
        '{3'd7, 3'd2, 3'd2, 3'd2, 3'd7}, '{3'd1, 3'd1, 3'd1, 3'd5, 3'd7},
        '{3'd5, 3'd5, 3'd6, 3'd5, 3'd5}, '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
        '{3'd7, 3'd7, 3'd5, 3'd5, 3'd5}, '{3'd7, 3'd5, 3'd5, 3'd5, 3'd5},
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd4, 3'd4},
        '{3'd7, 3'd5, 3'd5, 3'd7, 3'd1}, '{3'd7, 3'd5, 3'd6, 3'd5, 3'd5},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7}, '{3'd7, 3'd2, 3'd2, 3'd2, 3'd2},
        '{3'd5, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
        '{3'd5, 3'd5, 3'd5, 3'd7, 3'd7}, '{3'd5, 3'd5, 3'd2, 3'd5, 3'd5},
        '{3'd5, 3'd5, 3'd7, 3'd2, 3'd2}, '{3'd7, 3'd1, 3'd2, 3'd4, 3'd7}
    };

    function automatic t_cell_mask glyph_mask(t_glyph_idx g);
        t_cell_mask m;
        logic [2:0] bits;
        m = '0;
        for (int r = 0; r < GLYPH_H; r++) begin
            bits = GLYPH_ROM[g][r];
            m[r*GLYPH_W]     = bits[2];
            m[r*GLYPH_W + 1] = bits[1];
            m[r*GLYPH_W + 2] = bits[0];
        end
        return m;
    endfunction

    function automatic logic [2:0] cell_row(t_cell_idx i);
        logic [2:0] r;
        unique case (i) inside
            [4'd0:4'd2]:   r = 3'd0;
            [4'd3:4'd5]:   r = 3'd1;
            [4'd6:4'd8]:   r = 3'd2;
            [4'd9:4'd11]:  r = 3'd3;
            [4'd12:4'd14]: r = 3'd4;
            default:       r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cell_col(t_cell_idx i);
        logic [1:0] c;
        unique case (i) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12:  c = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13: c = 2'd1;
            default:                        c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/gpr3x5_ifs.sv =====
// Valid/ready channel interfaces: character items in, pixel items out.
// Depends on nothing.
interface gpr3x5_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         char_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [1:0]         scale;

    modport source (output valid, char_code, origin_x, origin_y, red, green, blue, scale,
                    input ready);
    modport sink   (input valid, char_code, origin_x, origin_y, red, green, blue, scale,
                    output ready);
endinterface

interface gpr3x5_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
                    last_pixel, output ready);
endinterface

// ===== sv/gpr3x5_front.sv =====
// Front end: accepts character items, folds case, picks the glyph, builds a job.
// Depends on gpr3x5_pkg and gpr3x5_in_if.
module gpr3x5_front (
    gpr3x5_in_if.sink         i_char,
    input  logic              i_q_full,
    output logic              o_push,
    output gpr3x5_pkg::t_job  o_job
);

    logic [7:0]             code;
    logic                   scale_ok;
    logic                   is_one;
    logic                   drawable;
    gpr3x5_pkg::t_glyph_idx glyph;

    always_comb begin
        code     = i_char.char_code;
        scale_ok = (i_char.scale == gpr3x5_pkg::SCALE_ONE) ||
                   (i_char.scale == gpr3x5_pkg::SCALE_TWO);
        is_one   = (i_char.scale == gpr3x5_pkg::SCALE_ONE);
        if (code >= gpr3x5_pkg::CH_LOWER_A && code <= gpr3x5_pkg::CH_LOWER_Z) begin
            code = code - gpr3x5_pkg::CASE_FOLD;
        end
        drawable = scale_ok;
        glyph    = '0;
        if (code >= gpr3x5_pkg::CH_UPPER_A && code <= gpr3x5_pkg::CH_UPPER_Z) begin
            glyph = gpr3x5_pkg::IDX_ALPHA + 6'(code - gpr3x5_pkg::CH_UPPER_A);
        end else if (code >= gpr3x5_pkg::CH_ZERO && code <= gpr3x5_pkg::CH_NINE) begin
            glyph = 6'(code - gpr3x5_pkg::CH_ZERO);
        end else if (is_one && code == gpr3x5_pkg::CH_BANG) begin
            glyph = gpr3x5_pkg::IDX_BANG;
        end else if (is_one && code == gpr3x5_pkg::CH_COLON) begin
            glyph = gpr3x5_pkg::IDX_COLON;
        end else begin
            drawable = 1'b0;
        end
    end

    // Undrawable items are taken and dropped here; they never reach the queue.
    assign i_char.ready = !i_q_full;
    assign o_push       = i_char.valid && !i_q_full && drawable;

    always_comb begin
        o_job.mask  = gpr3x5_pkg::glyph_mask(glyph);
        o_job.ox    = i_char.origin_x;
        o_job.oy    = i_char.origin_y;
        o_job.red   = i_char.red;
        o_job.green = i_char.green;
        o_job.blue  = i_char.blue;
        o_job.s2    = !is_one;
    end

endmodule

// ===== sv/gpr3x5_fifo.sv =====
// Two-entry job queue between front and back.
// Depends on gpr3x5_pkg.
module gpr3x5_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpr3x5_pkg::t_job  i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output gpr3x5_pkg::t_job  o_pop_data,
    output logic              o_empty
);

    gpr3x5_pkg::t_job r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== sv/gpr3x5_back.sv =====
// Back end: walks lit cells, one pixel a cycle to the output register unless stalled.
// Depends on gpr3x5_pkg, gpr3x5_out_if and the assertion macros.
`include "glyph_pixel_rasterizer_3x5_unit_macros.svh"

module gpr3x5_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  gpr3x5_pkg::t_job  i_job,
    output logic              o_pop,
    gpr3x5_out_if.source      o_pixel
);

    logic                   r_busy, n_busy;
    gpr3x5_pkg::t_cell_mask r_mask, n_mask;
    logic [15:0]            r_ox, n_ox;
    logic [15:0]            r_oy, n_oy;
    logic [7:0]             r_red, n_red;
    logic [7:0]             r_green, n_green;
    logic [7:0]             r_blue, n_blue;
    logic                   r_s2, n_s2;
    logic                   r_sx, n_sx;
    logic                   r_sy, n_sy;
    logic                   r_out_valid, n_out_valid;
    gpr3x5_pkg::t_pixel     r_out, n_out;

    gpr3x5_pkg::t_cell_idx  cur_cell;
    logic [2:0]             row;
    logic [1:0]             col;
    logic [2:0]             col_sc;
    logic [3:0]             row_sc;
    logic                   block_done;
    gpr3x5_pkg::t_cell_mask mask_next;
    logic                   advance;

    // Lowest lit cell is the next one in row-major order.
    always_comb begin
        cur_cell = '0;
        for (int i = gpr3x5_pkg::CELLS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                cur_cell = 4'(i);
            end
        end
        row        = gpr3x5_pkg::cell_row(cur_cell);
        col        = gpr3x5_pkg::cell_col(cur_cell);
        col_sc     = r_s2 ? {col, 1'b0} : {1'b0, col};
        row_sc     = r_s2 ? {row, 1'b0} : {1'b0, row};
        block_done = !r_s2 || (r_sx && r_sy);
        mask_next  = block_done ? (r_mask & (r_mask - gpr3x5_pkg::t_cell_mask'(1))) : r_mask;
        advance    = r_busy && (!r_out_valid || o_pixel.ready);
        o_pop      = !r_busy && !i_q_empty;
    end

    always_comb begin
        n_busy      = r_busy;
        n_mask      = r_mask;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_s2        = r_s2;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pixel.ready;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_mask  = i_job.mask;
            n_ox    = i_job.ox;
            n_oy    = i_job.oy;
            n_red   = i_job.red;
            n_green = i_job.green;
            n_blue  = i_job.blue;
            n_s2    = i_job.s2;
            n_sx    = 1'b0;
            n_sy    = 1'b0;
        end else if (advance) begin
            n_out_valid       = 1'b1;
            n_out.pixel_x     = r_ox + 16'(col_sc) + 16'(r_sx);
            n_out.pixel_y     = r_oy + 16'(row_sc) + 16'(r_sy);
            n_out.pixel_red   = r_red;
            n_out.pixel_green = r_green;
            n_out.pixel_blue  = r_blue;
            n_out.last_pixel  = (mask_next == '0);
            n_mask            = mask_next;
            n_busy            = (mask_next != '0);
            if (r_s2) begin
                n_sx = !r_sx;
                n_sy = r_sy ^ r_sx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sx        <= 1'b0;
            r_sy        <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_s2    <= n_s2;
        r_out   <= n_out;
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_out.pixel_x;
    assign o_pixel.pixel_y     = r_out.pixel_y;
    assign o_pixel.pixel_red   = r_out.pixel_red;
    assign o_pixel.pixel_green = r_out.pixel_green;
    assign o_pixel.pixel_blue  = r_out.pixel_blue;
    assign o_pixel.last_pixel  = r_out.last_pixel;

    `GPR_ASSERT(a_busy_has_cells, r_busy |-> (r_mask != '0), "busy with no lit cells left")
    `GPR_ASSERT(a_scale1_no_sub, (r_busy && !r_s2) |-> (!r_sx && !r_sy), "sub-offset at scale 1")
    `GPR_ASSERT(a_queued_job_drawable, !i_q_empty |-> (i_job.mask != '0), "empty glyph queued")

endmodule

// ===== sv/glyph_pixel_rasterizer_3x5_unit.sv =====
// Top level of the 3x5 bitmap font rasterizer: front, job queue and pixel back end.
// Depends on gpr3x5_pkg, gpr3x5_ifs, gpr3x5_front, gpr3x5_fifo and gpr3x5_back.

// Takes one character item (code, origin, color, scale) and writes one pixel item for
// every lit cell of its 3x5 glyph, each cell as a scale-by-scale block, row-major, with
// last_pixel set on the final write. Letters (either case) and digits draw at scale 1
// or 2; '!' and ':' draw at scale 1 only; every other code, and scale 0 or 3, is
// taken and writes nothing. Coordinates wrap at 16 bits.
// Timing: the front classifies and queues an item in the cycle it is accepted; the
// back loads a job, then writes its pixels from the single output register, one
// pixel a cycle while the pixel side takes them. Undrawable items take no back end
// time. The two-entry queue lets the input keep accepting while pixels drain.
// Output is held in a register; a stall on the pixel side never drops or repeats an item.
module glyph_pixel_rasterizer_3x5_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpr3x5_in_if.sink     i_char,
    gpr3x5_out_if.source  o_pixel
);

    // front -> queue
    logic             push;
    logic             q_full;
    gpr3x5_pkg::t_job push_job;

    // queue -> back
    logic             pop;
    logic             q_empty;
    gpr3x5_pkg::t_job head_job;

    gpr3x5_front u_front (
        .i_char   (i_char),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    gpr3x5_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (head_job),
        .o_empty     (q_empty)
    );

    gpr3x5_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_pixel   (o_pixel)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the 3x5 glyph rasterizer: drives character items and checks
// every pixel item against a built-in font predictor.
// Depends on gpr3x5_pkg, gpr3x5_ifs and glyph_pixel_rasterizer_3x5_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 126;
    localparam int STALL_PCT      = 19;    // percent of cycles each side sits idle
    localparam int STEADY_FIRST   = 50;    // random items in this window run with no idling
    localparam int STEADY_LAST    = 89;
    localparam int DRAIN_POINT    = 100;   // sender waits here until all pixels are back
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
    localparam int TAIL_CYCLES    = 64;    // > one 52-pixel glyph plus the job load
    localparam int REPORT_MAX     = 10;

    // Short local names for the codes used in the stimulus table.
    localparam logic [7:0] CH_LOWER_A = gpr3x5_pkg::CH_LOWER_A;
    localparam logic [7:0] CH_LOWER_Z = gpr3x5_pkg::CH_LOWER_Z;
    localparam logic [7:0] CH_UPPER_A = gpr3x5_pkg::CH_UPPER_A;
    localparam logic [7:0] CH_UPPER_Z = gpr3x5_pkg::CH_UPPER_Z;
    localparam logic [7:0] CH_ZERO    = gpr3x5_pkg::CH_ZERO;
    localparam logic [7:0] CH_NINE    = gpr3x5_pkg::CH_NINE;
    localparam logic [7:0] CH_BANG    = gpr3x5_pkg::CH_BANG;
    localparam logic [7:0] CH_COLON   = gpr3x5_pkg::CH_COLON;
    localparam logic [1:0] SCALE_ONE  = gpr3x5_pkg::SCALE_ONE;
    localparam logic [1:0] SCALE_TWO  = gpr3x5_pkg::SCALE_TWO;

    // Scale codes with no meaning; the block takes them and draws nothing.
    localparam logic [1:0] SCALE_ZERO  = 2'd0;
    localparam logic [1:0] SCALE_THREE = 2'd3;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [1:0]  scale;
    } t_char_item;

    // A directed row either goes through the predictor or carries its pixels typed in
    // (by_hand): hand_n offsets taken in order from HAND_DX/HAND_DY, zero for no pixels.
    typedef struct packed {
        t_char_item  item;
        logic        by_hand;
        logic [2:0]  hand_n;
    } t_dir_row;

    // Font, one octal digit per row, top row first; in a row, bit 2 is the left column.
    // Order: digits 0-9, colon, exclamation mark, then A-Z.
    localparam logic [14:0] FONT_ROWS [gpr3x5_pkg::GLYPHS] = '{
        15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
        15'o74717, 15'o74757, 15'o71222, 15'o75757, 15'o75717,
        15'o02020, 15'o22202,
        15'o75755, 15'o65656, 15'o74447, 15'o65556, 15'o74747,
        15'o74744, 15'o74557, 15'o55755, 15'o72227, 15'o11157,
        15'o55655, 15'o44447, 15'o77555, 15'o75555, 15'o75557,
        15'o75744, 15'o75571, 15'o75655, 15'o74717, 15'o72222,
        15'o55557, 15'o55552, 15'o55577, 15'o55255, 15'o55722,
        15'o71247
    };

    // Typed-in pixels: '!' is a column of four cells with a gap above the bottom one,
    // ':' two dots in the middle column.
    localparam int HAND_DX [6] = '{1, 1, 1, 1,   1, 1};
    localparam int HAND_DY [6] = '{0, 1, 2, 4,   1, 3};

    localparam t_dir_row DIRECTED [24] = '{
        // letters and digits at the corners of the coordinate and color ranges
        '{'{CH_UPPER_A, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, SCALE_ONE}, 1'b0, 3'd0},
        '{'{CH_LOWER_Z, 16'h7fff, 16'h7fff, 8'hff, 8'hff, 8'hff, SCALE_TWO}, 1'b0, 3'd0},
        '{'{CH_ZERO,    16'h8000, 16'h8000, 8'h00, 8'hff, 8'h00, SCALE_ONE}, 1'b0, 3'd0},
        '{'{CH_NINE,    16'hffff, 16'hffff, 8'hff, 8'h00, 8'hff, SCALE_TWO}, 1'b0, 3'd0},
        '{'{CH_UPPER_Z, 16'h1234, 16'h00ab, 8'h5a, 8'ha5, 8'h3c, SCALE_ONE}, 1'b0, 3'd0},
        '{'{CH_LOWER_A, 16'h0010, 16'hfff0, 8'h81, 8'h7e, 8'h01, SCALE_ONE}, 1'b0, 3'd0},
        // punctuation draws at scale 1 only
        '{'{CH_BANG,    16'h0000, 16'h0000, 8'h11, 8'h22, 8'h33, SCALE_ONE}, 1'b1, 3'd4},
        '{'{CH_COLON,   16'h0000, 16'h0000, 8'h44, 8'h55, 8'h66, SCALE_ONE}, 1'b1, 3'd2},
        '{'{CH_BANG,    16'h0040, 16'h0040, 8'hff, 8'hff, 8'hff, SCALE_TWO}, 1'b1, 3'd0},
        '{'{CH_COLON,   16'h0040, 16'h0040, 8'hff, 8'hff, 8'hff, SCALE_TWO}, 1'b1, 3'd0},
        // unknown codes: space, top of the high half, bottom of the high half
        '{'{8'h20,      16'h0001, 16'h0001, 8'h01, 8'h02, 8'h03, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'hff,      16'h0001, 16'h0001, 8'h01, 8'h02, 8'h03, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'h80,      16'h0001, 16'h0001, 8'h01, 8'h02, 8'h03, SCALE_TWO}, 1'b1, 3'd0},
        // a good letter with a meaningless scale
        '{'{CH_UPPER_A, 16'h0002, 16'h0002, 8'h10, 8'h20, 8'h30, SCALE_ZERO}, 1'b1, 3'd0},
        '{'{CH_UPPER_A, 16'h0002, 16'h0002, 8'h10, 8'h20, 8'h30, SCALE_THREE}, 1'b1, 3'd0},
        // '8' lights 13 cells: the largest burst, 52 pixels, wrapping both axes
        '{'{8'h38,      16'h7ffe, 16'h7ffe, 8'hc3, 8'h3c, 8'h99, SCALE_TWO}, 1'b0, 3'd0},
        // neighbors of the letter and digit ranges: '@' '[' '/' '`' '{' and NUL
        '{'{8'h40,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'h5b,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'h2f,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_TWO}, 1'b1, 3'd0},
        '{'{8'h60,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'h7b,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_TWO}, 1'b1, 3'd0},
        '{'{8'h00,      16'h0003, 16'h0003, 8'h00, 8'h00, 8'h00, SCALE_ONE}, 1'b1, 3'd0},
        '{'{8'h4d,      16'h0100, 16'h0200, 8'h0f, 8'hf0, 8'h55, SCALE_ONE}, 1'b0, 3'd0},
        '{'{8'h77,      16'hfffe, 16'h0001, 8'haa, 8'h55, 8'hcc, SCALE_TWO}, 1'b0, 3'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;

    gpr3x5_pkg::t_pixel pending_pixels [$];  // pixel writes still owed, oldest first
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     hand_cursor = 0;

    gpr3x5_in_if  char_if ();
    gpr3x5_out_if pix_if ();

    glyph_pixel_rasterizer_3x5_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_if),
        .o_pixel (pix_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Font predictor
    // ------------------------------------------------------------------

    // Font index for a code at a scale, or -1 when nothing is drawn.
    function automatic int glyph_index(logic [7:0] code, logic [1:0] scale);
        logic [7:0] c;
        c = code;
        if (scale != SCALE_ONE && scale != SCALE_TWO)
            return -1;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - gpr3x5_pkg::CASE_FOLD;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return int'(gpr3x5_pkg::IDX_ALPHA) + int'(c) - int'(CH_UPPER_A);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (scale == SCALE_ONE && c == CH_BANG)
            return int'(gpr3x5_pkg::IDX_BANG);
        if (scale == SCALE_ONE && c == CH_COLON)
            return int'(gpr3x5_pkg::IDX_COLON);
        return -1;
    endfunction

    // Queues the pixel writes one character draws: lit cells row-major, each cell a
    // scale x scale block, rows of the block top first, last flag on the final write.
    task automatic predict_pixels(input t_char_item it);
        int                 g;
        int                 s;
        int                 xi;
        int                 yi;
        logic [2:0]         bits;
        gpr3x5_pkg::t_pixel px;
        gpr3x5_pkg::t_pixel burst [$];
        g = glyph_index(it.code, it.scale);
        if (g < 0)
            return;
        s = int'(it.scale);
        for (int row = 0; row < gpr3x5_pkg::GLYPH_H; row++) begin
            bits = FONT_ROWS[g][3 * (gpr3x5_pkg::GLYPH_H - 1 - row) +: 3];
            for (int col = 0; col < gpr3x5_pkg::GLYPH_W; col++) begin
                if (!bits[2 - col])
                    continue;
                for (int sy = 0; sy < s; sy++) begin
                    for (int sx = 0; sx < s; sx++) begin
                        xi = int'(it.ox) + col * s + sx;
                        yi = int'(it.oy) + row * s + sy;
                        px.pixel_x     = xi[15:0];
                        px.pixel_y     = yi[15:0];
                        px.pixel_red   = it.red;
                        px.pixel_green = it.green;
                        px.pixel_blue  = it.blue;
                        px.last_pixel  = 1'b0;
                        burst.push_back(px);
                    end
                end
            end
        end
        burst[burst.size() - 1].last_pixel = 1'b1;
        foreach (burst[k])
            pending_pixels.push_back(burst[k]);
    endtask

    // Typed-in pixels of a directed row, offsets taken from the hand table in order.
    task automatic expect_by_hand(input t_char_item it, input int n);
        int                 xi;
        int                 yi;
        gpr3x5_pkg::t_pixel px;
        for (int k = 0; k < n; k++) begin
            xi = int'(it.ox) + HAND_DX[hand_cursor];
            yi = int'(it.oy) + HAND_DY[hand_cursor];
            hand_cursor++;
            px.pixel_x     = xi[15:0];
            px.pixel_y     = yi[15:0];
            px.pixel_red   = it.red;
            px.pixel_green = it.green;
            px.pixel_blue  = it.blue;
            px.last_pixel  = (k == n - 1);
            pending_pixels.push_back(px);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly anywhere; one time in eight a few steps from a signed or unsigned wrap.
    function automatic logic [15:0] random_coord();
        logic [15:0] base;
        if ($urandom_range(0, 7) != 0)
            return 16'($urandom_range(0, 16'hffff));
        base = $urandom_range(0, 1) ? 16'h7ffa : 16'hfffa;
        return base + 16'($urandom_range(0, 11));
    endfunction

    // Mostly drawable characters with random placement and color; the rest is
    // punctuation, which scale 2 drops, any byte at all, and bad scales.
    function automatic t_char_item random_char();
        t_char_item it;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.code = CH_UPPER_A + 8'($urandom_range(0, 25));
        else if (pick < 45)
            it.code = CH_LOWER_A + 8'($urandom_range(0, 25));
        else if (pick < 62)
            it.code = CH_ZERO + 8'($urandom_range(0, 9));
        else if (pick < 70)
            it.code = $urandom_range(0, 1) ? CH_BANG : CH_COLON;
        else
            it.code = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 19);
        if (pick < 9)
            it.scale = SCALE_ONE;
        else if (pick < 18)
            it.scale = SCALE_TWO;
        else if (pick == 18)
            it.scale = SCALE_ZERO;
        else
            it.scale = SCALE_THREE;
        it.ox    = random_coord();
        it.oy    = random_coord();
        it.red   = 8'($urandom_range(0, 255));
        it.green = 8'($urandom_range(0, 255));
        it.blue  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Presents one character, after random idle cycles, and returns in the time step
    // of its handshake. valid stays up for a follow-on item with no idle between.
    task automatic send_char(input t_char_item it);
        while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= it.code;
        char_if.origin_x  <= it.ox;
        char_if.origin_y  <= it.oy;
        char_if.red       <= it.red;
        char_if.green     <= it.green;
        char_if.blue      <= it.blue;
        char_if.scale     <= it.scale;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
    endtask

    // Drops valid and holds off until every owed pixel is back. The wait loop runs
    // before its test, so valid is never lowered and raised in the same step.
    task automatic hold_until_drained();
        char_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_char_item it;
        rst_n             <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= '0;
        char_if.origin_x  <= '0;
        char_if.origin_y  <= '0;
        char_if.red       <= '0;
        char_if.green     <= '0;
        char_if.blue      <= '0;
        char_if.scale     <= SCALE_ONE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows; expectations are queued in the step of the handshake, ahead of
        // the earliest pixel the item can cause.
        for (int r = 0; r < $size(DIRECTED); r++) begin
            send_char(DIRECTED[r].item);
            if (DIRECTED[r].by_hand)
                expect_by_hand(DIRECTED[r].item, int'(DIRECTED[r].hand_n));
            else
                predict_pixels(DIRECTED[r].item);
        end
        hold_until_drained();

        // Random part, with a stretch where neither side idles and one full drain.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady <= (n >= STEADY_FIRST && n <= STEADY_LAST);
            if (n == DRAIN_POINT)
                hold_until_drained();
            it = random_char();
            send_char(it);
            predict_pixels(it);
        end
        hold_until_drained();

        // Anything the block still sends now has no expectation and fails.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Pixel side back-pressure: random stalls, none during the steady stretch.
    always @(posedge clk) begin
        pix_if.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // ------------------------------------------------------------------
    // Pixel checker: each accepted pixel against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        gpr3x5_pkg::t_pixel got;
        gpr3x5_pkg::t_pixel want;
        if (rst_n && pix_if.valid && pix_if.ready) begin
            got.pixel_x     = pix_if.pixel_x;
            got.pixel_y     = pix_if.pixel_y;
            got.pixel_red   = pix_if.pixel_red;
            got.pixel_green = pix_if.pixel_green;
            got.pixel_blue  = pix_if.pixel_blue;
            got.last_pixel  = pix_if.last_pixel;
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h last=%b",
                             got.pixel_x, got.pixel_y, got.pixel_red, got.pixel_green,
                             got.pixel_blue, got.last_pixel);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"pixel mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h ",
                                  "last=%b, got x=%0d y=%0d rgb=%02h%02h%02h last=%b"},
                                 want.pixel_x, want.pixel_y, want.pixel_red,
                                 want.pixel_green, want.pixel_blue, want.last_pixel,
                                 got.pixel_x, got.pixel_y, got.pixel_red,
                                 got.pixel_green, got.pixel_blue, got.last_pixel);
                end
            end
        end
    end

    // Watchdog: a stuck handshake on both sides ends the run.
    always @(posedge clk) begin
        if (!rst_n || (char_if.valid && char_if.ready) || (pix_if.valid && pix_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
